// ===== hdl/packet_frame_receiver_defines.svh =====
// Assertion macros used by the packet frame receiver core.
`ifndef PACKET_FRAME_RECEIVER_DEFINES_SVH
`define PACKET_FRAME_RECEIVER_DEFINES_SVH

// Check an expression at every clock edge outside reset.
`define PFR_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define PFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pfr_pkg.sv =====
// Types and constants for the packet frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

    localparam int MAX_DATA = 64;
    localparam logic [7:0] MAX_DATA_B = 8'(MAX_DATA);
    localparam logic [7:0] START_BYTE_RESET = 8'd126;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4
    } phase_t;

    typedef struct packed {
        logic       is_end;
        logic [7:0] frame_type;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic       checksum_ok;
        logic       length_capped;
    } pfr_result_t;

endpackage

`default_nettype wire

// ===== hdl/pfr_in_stage.sv =====
// Input register that holds one received byte until the deframer takes it.
`timescale 1ns / 1ps
`default_nettype none

module pfr_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic       take,
    output logic            item_valid,
    output logic [7:0]      item_byte
);
    import pfr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pfr_core.sv =====
// Frame state machine, checksum and payload counting for the receiver.
`timescale 1ns / 1ps
`default_nettype none
`include "packet_frame_receiver_defines.svh"

module pfr_core (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       item_valid,
    input  wire logic [7:0] item_byte,
    input  wire logic       out_free,
    output logic            take,
    output logic            res_valid,
    output pfr_pkg::pfr_result_t res
);
    import pfr_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] start_byte_reg;
    logic [7:0] count_reg;
    logic [7:0] count_next;
    logic [7:0] xor_reg;
    logic [7:0] xor_next;
    logic [7:0] type_reg;
    logic [7:0] type_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [7:0] count_inc;
    logic       produces;

    assign count_inc = count_reg + 8'd1;
    // Bytes that give no result never wait on the output side.
    assign take      = item_valid && (out_free || !produces);
    assign res_valid = take && produces;

    // Next state
    always_comb begin
        phase_next = phase_reg;
        if (take) begin
            case (phase_reg)
                PH_TYPE: begin
                    phase_next = PH_LENGTH;
                end
                PH_LENGTH: begin
                    phase_next = (item_byte == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                    if (count_inc >= length_reg || count_inc >= MAX_DATA_B) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = (item_byte == start_byte_reg) ? PH_TYPE : PH_IDLE;
                end
            endcase
        end
    end

    // Outputs of the state machine
    always_comb begin
        produces          = 1'b0;
        res.is_end        = 1'b0;
        res.frame_type    = type_reg;
        res.payload_byte  = 8'd0;
        res.byte_index    = count_reg;
        res.frame_length  = length_reg;
        res.checksum_ok   = 1'b0;
        res.length_capped = 1'b0;
        case (phase_reg)
            PH_DATA: begin
                produces         = 1'b1;
                res.payload_byte = item_byte;
            end
            PH_CHECK: begin
                produces          = 1'b1;
                res.is_end        = 1'b1;
                res.checksum_ok   = (item_byte == xor_reg);
                res.length_capped = (length_reg > MAX_DATA_B);
            end
            default: begin
                produces = 1'b0;
            end
        endcase
    end

    // Frame datapath
    always_comb begin
        count_next  = count_reg;
        xor_next    = xor_reg;
        type_next   = type_reg;
        length_next = length_reg;
        if (take) begin
            case (phase_reg)
                PH_TYPE: begin
                    type_next = item_byte;
                    xor_next  = item_byte;
                end
                PH_LENGTH: begin
                    length_next = item_byte;
                    xor_next    = xor_reg ^ item_byte;
                    count_next  = 8'd0;
                end
                PH_DATA: begin
                    xor_next   = xor_reg ^ item_byte;
                    count_next = count_inc;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            start_byte_reg <= START_BYTE_RESET;
            count_reg      <= 8'd0;
            xor_reg        <= 8'd0;
            type_reg       <= 8'd0;
            length_reg     <= 8'd0;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            xor_reg    <= xor_next;
            type_reg   <= type_next;
            length_reg <= length_next;
            if (cfg_we) begin
                start_byte_reg <= cfg_wdata;
            end
        end
    end

    `PFR_ASSERT(a_count_capped, count_reg <= MAX_DATA_B, "payload count beyond cap")
    `PFR_ASSERT_IMP(a_data_index, res_valid && !res.is_end, res.byte_index < MAX_DATA_B,
                    "payload index beyond cap")
    `PFR_ASSERT_NXT(a_end_to_idle, res_valid && res.is_end, phase_reg == PH_IDLE,
                    "end result did not close the frame")
    `PFR_ASSERT_NXT(a_len_zero_skip, take && phase_reg == PH_LENGTH && item_byte == 8'd0,
                    phase_reg == PH_CHECK, "zero length did not skip to checksum")

endmodule

`default_nettype wire

// ===== hdl/pfr_out_stage.sv =====
// Result register that holds one result until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module pfr_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 res_valid,
    input  wire pfr_pkg::pfr_result_t res,
    output logic                      out_free,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output pfr_pkg::pfr_result_t      m_res
);
    import pfr_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    pfr_result_t res_reg;

    assign out_free = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_res    = res_reg;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/packet_frame_receiver.sv =====
// Top level of the packet frame receiver: byte deframer with XOR checksum.
//
//   Channel  Ports                         Moves
//   s_       s_valid/s_ready, s_rx_byte    one received byte per transfer
//   m_       m_valid/m_ready, m_* fields   one payload or end result per transfer
//   cfg_     cfg_we, cfg_wdata             start byte register, no wait
//
// One byte per cycle sustained while the sink keeps m_ready high; each byte is
// held in the input register and, if it gives a result, then in the result register.
// Reset (aresetn low, synchronous) empties both registers, returns to idle
// and loads start byte 126.
// A stalled result register holds the input register only while the waiting
// byte gives a result; dropped, start, type and length bytes pass regardless.
`timescale 1ns / 1ps
`default_nettype none

module packet_frame_receiver (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_is_end,
    output logic [7:0]      m_frame_type,
    output logic [7:0]      m_payload_byte,
    output logic [7:0]      m_byte_index,
    output logic [7:0]      m_frame_length,
    output logic            m_checksum_ok,
    output logic            m_length_capped
);
    import pfr_pkg::*;

    logic        take;
    logic        item_valid;
    logic [7:0]  item_byte;
    logic        out_free;
    logic        res_valid;
    pfr_result_t res;
    pfr_result_t m_res;

    pfr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    pfr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    pfr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_is_end        = m_res.is_end;
    assign m_frame_type    = m_res.frame_type;
    assign m_payload_byte  = m_res.payload_byte;
    assign m_byte_index    = m_res.byte_index;
    assign m_frame_length  = m_res.frame_length;
    assign m_checksum_ok   = m_res.checksum_ok;
    assign m_length_capped = m_res.length_capped;

endmodule

`default_nettype wire
